>>> design/sem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants for the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W = 24;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       flush;
    } sem_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } sem_out_t;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic rd_en;     // read line stores at current column
        logic shift;     // shift window, write line stores
        logic calc;      // register masked sums
        logic sq;        // register squares
        logic root_start;
        logic load_out;
    } sem_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic root_done;
    } sem_sts_t;

endpackage

>>> design/sem_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end
endmodule

>>> design/sem_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_datapath
// line stores, window, sobel sums, squares and serial rounded root
// ----------------------------------------------------------------------------
module sem_datapath
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  sem_cmd_t      cmd,
    input  logic [AW-1:0] col,
    input  sem_in_t       pix_in,
    input  logic [8:0]    mask,      // bit r*3+c masks window cell (r,c)
    input  logic          last,
    output sem_sts_t      sts,
    output sem_out_t      res
);
    logic [PIX_W-1:0] top_rd, mid_rd, px;
    logic [PIX_W-1:0] win_reg [3][3];
    logic [10:0] gx_reg [3], gy_reg [3];
    logic [20:0] sq_reg [3];
    logic [7:0]  k_reg;
    logic [7:0]  n_reg [3];
    logic        busy_reg, last_reg;
    logic        done;

    assign px = pix_in.flush ? '0 :
        {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_a (
        .aclk(aclk), .we(cmd.shift), .re(cmd.rd_en), .addr(col),
        .wdata(mid_rd), .rdata(top_rd)
    );
    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_b (
        .aclk(aclk), .we(cmd.shift), .re(cmd.rd_en), .addr(col),
        .wdata(px), .rdata(mid_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= px;
        end
    end

    // masked sums per channel; mask bit r*3+c high means black
    logic [11:0] v [3][3][3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    v[ch][r][c] = mask[r*3+c] ? 12'd0 :
                        {4'd0, win_reg[r][c][(2-ch)*8 +: 8]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            for (int ch = 0; ch < 3; ch++) begin
                gx_reg[ch] <= 11'((v[ch][0][2] + (v[ch][1][2] << 1) + v[ch][2][2])
                    - (v[ch][0][0] + (v[ch][1][0] << 1) + v[ch][2][0]));
                gy_reg[ch] <= 11'((v[ch][2][0] + (v[ch][2][1] << 1) + v[ch][2][2])
                    - (v[ch][0][0] + (v[ch][0][1] << 1) + v[ch][0][2]));
            end
            last_reg <= last;
        end
        if (cmd.sq) begin
            for (int ch = 0; ch < 3; ch++) begin
                sq_reg[ch] <= 21'($signed(gx_reg[ch]) * $signed(gx_reg[ch])
                    + $signed(gy_reg[ch]) * $signed(gy_reg[ch]));
            end
        end
    end

    // count k in 0..254 with k(k+1) < s, one k per cycle
    logic [20:0] kk;
    assign kk = 21'(k_reg * (k_reg + 9'd1));
    assign done = busy_reg && (k_reg == 8'd254);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else if (cmd.root_start) begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
            for (int ch = 0; ch < 3; ch++) n_reg[ch] <= '0;
        end else if (busy_reg) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (kk < sq_reg[ch]) n_reg[ch] <= n_reg[ch] + 8'd1;
            end
            k_reg <= k_reg + 8'd1;
            if (done) busy_reg <= 1'b0;
        end
    end

    assign sts.root_done = done;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            res.red_out   <= n_reg[0];
            res.green_out <= n_reg[1];
            res.blue_out  <= n_reg[2];
            res.frame_end <= last_reg;
        end
    end
endmodule

>>> design/sem_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ctrl
// controller: handshake, raster counters, border mask, sequencing
// ----------------------------------------------------------------------------
module sem_ctrl
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_index,
    input  logic [12:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  sem_sts_t      sts,
    output sem_cmd_t      cmd,
    output logic [AW-1:0] col,
    output logic [8:0]    mask,
    output logic          last
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_SHF  = 6'b000100,
        ST_SQ   = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [10:0] fw_reg;
    logic [12:0] fh_reg;
    logic [13:0] col_reg;
    logic [16:0] row_reg;
    logic [13:0] lag_reg;
    logic        mv_reg;
    logic [13:0] w;
    logic [16:0] h;
    logic [13:0] cc;
    logic [17:0] cr;
    logic        emit, do_out;

    assign w = (fw_reg == 0) ? 14'd1 :
        (32'(fw_reg) > MAX_WIDTH) ? 14'(MAX_WIDTH) : 14'(fw_reg);
    assign h = (fh_reg == 0) ? 17'd1 :
        (32'(fh_reg) > MAX_HEIGHT) ? 17'(MAX_HEIGHT) : 17'(fh_reg);

    assign col = col_reg[AW-1:0];
    assign cc  = (col_reg == 0) ? w - 14'd1 : col_reg - 14'd1;
    assign cr  = (col_reg == 0) ? {1'b0, row_reg} - 18'd2 : {1'b0, row_reg} - 18'd1;
    assign emit = lag_reg >= w + 14'd1;
    assign do_out = emit && !cr[17];
    assign last = (cr[16:0] == h - 17'd1) && (cc == w - 14'd1);

    always_comb begin
        logic b_c0, b_c2, b_r0, b_r2;
        b_c0 = (cc == 0);
        b_c2 = (cc == w - 14'd1);
        b_r0 = (cr[16:0] == 0);
        b_r2 = (cr[16:0] == h - 17'd1);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mask[r*3+c] = (c == 0 && b_c0) || (c == 2 && b_c2) ||
                    (r == 0 && b_r0) || (r == 2 && b_r2);
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.shift  = 1'b1;
                state_next = ST_SHF;
            end
            ST_SHF: begin
                if (do_out) begin
                    cmd.calc   = 1'b1;
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQ: begin
                cmd.sq         = 1'b1;
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                if (sts.root_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fw_reg    <= 11'd640;
            fh_reg    <= 13'd480;
            col_reg   <= '0;
            row_reg   <= '0;
            lag_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    fw_reg <= cfg_data[10:0];
                end else begin
                    fh_reg <= cfg_data;
                end
                col_reg <= '0;
                row_reg <= '0;
                lag_reg <= '0;
            end else if (state_reg == ST_SHF) begin
                if (!emit) lag_reg <= lag_reg + 14'd1;
                if (do_out && last) begin
                    col_reg <= '0;
                    row_reg <= '0;
                    lag_reg <= '0;
                end else if (col_reg + 14'd1 >= w) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 17'd1;
                end else begin
                    col_reg <= col_reg + 14'd1;
                end
            end
        end
    end
endmodule

>>> design/sobel_edge_magnitude_rgb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// 3x3 sobel edge magnitude per colour channel on a raster rgb stream
// ----------------------------------------------------------------------------
// channel  | ports                         | beat
// input    | s_valid s_ready s_data        | one pixel or flush
// result   | m_valid m_ready m_data        | one magnitude triple
// config   | cfg_wr_en cfg_index cfg_data  | one register write
// a beat with no result goes through read and shift states only; one with
// a result also waits on the serial rounded root, one candidate per cycle
// a new beat is taken while a result waits in the output register
// reset: synchronous active low, no clearing pass
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  sem_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output sem_out_t    m_data
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    sem_cmd_t      cmd;
    sem_sts_t      sts;
    logic [AW-1:0] col;
    logic [8:0]    mask;
    logic          last;
    sem_in_t       pix_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pix_reg <= s_data;
        end
    end

    sem_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .s_valid(s_valid),
        .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd), .col(col), .mask(mask), .last(last)
    );

    sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .col(col),
        .pix_in(pix_reg), .mask(mask), .last(last), .sts(sts), .res(m_data)
    );
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the sobel edge magnitude core against a cycle-free model of the
// filter: small frames of random rgb pixels with flush padding, register
// clamping, restarts by register write, random idling on both channels and
// a long output hold-off that stalls the input
// ----------------------------------------------------------------------------
module testbench;
    import sem_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 4096;
    localparam int STALL_LIMIT = 50000;
    localparam int SETTLE      = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = REG_FRAME_WIDTH;
    logic [12:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sem_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    sem_out_t    m_data;

    sobel_edge_magnitude_rgb_core dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // model state
    logic [23:0] row_old [MAX_W];
    logic [23:0] row_new [MAX_W];
    logic [23:0] win [3][3];
    int          col_pos, row_pos, seen;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    sem_out_t    mag_queue [$];
    int          errors = 0;
    int          beats_sent = 0;
    int          src_idle = 0, snk_idle = 0;
    int          snk_hold = 0;
    int          quiet = 0;

    function automatic int round_root(int s);
        int n = 0;
        for (int k = 0; k < 255; k++) if (k * (k + 1) < s) n++;
        return n;
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        seen = 0;
    endfunction

    function automatic void predict_mag(sem_in_t b);
        int w, h, col, cc, cr, gx, gy;
        int v [3][3];
        logic [23:0] px, top, mid;
        logic [23:0] m [3][3];
        logic emit, last;
        sem_out_t r;
        w = (width_reg < 1) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
        h = (height_reg < 1) ? 1 : (height_reg > MAX_H) ? MAX_H : height_reg;
        col = col_pos;
        px = b.flush ? 24'h0 : {b.red_in, b.green_in, b.blue_in};
        top = row_old[col];
        mid = row_new[col];
        row_old[col] = mid;
        row_new[col] = px;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;
        if (col == 0) begin
            cc = w - 1;
            cr = row_pos - 2;
        end else begin
            cc = col - 1;
            cr = row_pos - 1;
        end
        emit = seen >= w + 1;
        if (!emit) seen++;
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos = col + 1;
        end
        if (!emit || cr < 0) return;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = ((j == 0 && cc == 0) || (j == 2 && cc == w - 1) ||
                           (i == 0 && cr == 0) || (i == 2 && cr == h - 1))
                          ? 24'h0 : win[i][j];
        last = (cr == h - 1) && (cc == w - 1);
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    v[i][j] = int'((m[i][j] >> (16 - 8 * ch)) & 24'hFF);
            gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
            gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
            case (ch)
                0: r.red_out = 8'(round_root(gx * gx + gy * gy));
                1: r.green_out = 8'(round_root(gx * gx + gy * gy));
                default: r.blue_out = 8'(round_root(gx * gx + gy * gy));
            endcase
        end
        r.frame_end = last;
        mag_queue.push_back(r);
        if (last) restart_frame();
    endfunction

    // result side
    always @(negedge aclk) begin
        if (snk_hold > 0) begin
            snk_hold <= snk_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mag_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                if (m_data.red_out !== mag_queue[0].red_out)
                    $display("%0t: red_out expected %0d actual %0d", $time,
                             mag_queue[0].red_out, m_data.red_out);
                if (m_data.green_out !== mag_queue[0].green_out)
                    $display("%0t: green_out expected %0d actual %0d", $time,
                             mag_queue[0].green_out, m_data.green_out);
                if (m_data.blue_out !== mag_queue[0].blue_out)
                    $display("%0t: blue_out expected %0d actual %0d", $time,
                             mag_queue[0].blue_out, m_data.blue_out);
                if (m_data.frame_end !== mag_queue[0].frame_end)
                    $display("%0t: frame_end expected %0d actual %0d", $time,
                             mag_queue[0].frame_end, m_data.frame_end);
                if (m_data !== mag_queue[0]) errors++;
                void'(mag_queue.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with valid left high
    task automatic send_beat(sem_in_t b);
        if ($urandom_range(99) < src_idle) begin
            s_valid = 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle);
        end
        s_valid = 1'b1;
        s_data = b;
        do @(posedge aclk); while (!s_ready);
        predict_mag(b);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
        sem_in_t x;
        x.red_in = r;
        x.green_in = g;
        x.blue_in = b;
        x.flush = fl;
        send_beat(x);
    endtask

    function automatic logic [7:0] rand_level();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random(int flush_pct);
        send_pixel(rand_level(), rand_level(), rand_level(), $urandom_range(99) < flush_pct);
    endtask

    task automatic send_flushes(int n);
        for (int i = 0; i < n; i++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'b1);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (mag_queue.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [12:0] val);
        drain();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
        else height_reg = val;
        restart_frame();
    endtask

    task automatic frame_size(int w, int h);
        write_reg(REG_FRAME_WIDTH, 13'(w));
        write_reg(REG_FRAME_HEIGHT, 13'(h));
    endtask

    task automatic test_directed();
        frame_size(3, 3);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'h01, 1'b0);
        send_flushes(4);
        // zero registers clamp to a single pixel frame
        frame_size(0, 0);
        send_pixel(8'hFF, 8'h80, 8'h7F, 1'b0);
        send_flushes(2);
        drain();
    endtask

    task automatic test_clamp();
        // oversize width clamps to the line store depth
        frame_size(13'h1FFF, 2);
        for (int i = 0; i < MAX_W + 6; i++) send_random(6);
        drain();
        // oversize height, restarted by a write well before the end
        frame_size(2, 13'h1FFF);
        for (int i = 0; i < 30; i++) send_random(6);
        write_reg(REG_FRAME_HEIGHT, MAX_H);
        for (int i = 0; i < 20; i++) send_random(6);
        drain();
    endtask

    task automatic test_random(int n);
        int w, h, stop;
        stop = beats_sent + n;
        while (beats_sent < stop) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            frame_size(w, h);
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(9) == 0) begin
                    // broken frame, cut short by a register write
                    repeat ($urandom_range(w * h)) send_random(10);
                    break;
                end
                repeat (w * h) send_random(6);
                send_flushes(w + 1);
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        frame_size(4, 4);
        snk_hold = 3000;
        for (int i = 0; i < 16; i++) send_random(0);
        send_flushes(5);
        drain();
    endtask

    initial begin
        width_reg = 11'd640;
        height_reg = 13'd480;
        restart_frame();
        for (int i = 0; i < MAX_W; i++) begin
            row_old[i] = '0;
            row_new[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        src_idle = 8;
        snk_idle = 55;
        test_random(75);
        src_idle = 55;
        snk_idle = 8;
        test_random(75);
        test_backpressure();
        src_idle = 0;
        snk_idle = 0;
        test_random(75);
        test_clamp();
        s_valid = 1'b0;
        while (mag_queue.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
